@@ rtl/bpa_pkg.sv @@
// Shared constants, types and datapath command codes for the buddy page allocator.
// No dependencies.
package bpa_pkg;

	localparam int PAGE_COUNT = 1024;
	localparam int PG_W       = 10;
	localparam int LINK_W     = 11;
	localparam int MAX_ORDER  = 5;
	localparam int ORD_W      = 3;
	localparam int HEADS      = MAX_ORDER + 1;
	localparam int ADDR_W     = 48;
	localparam int SIZE_W     = 32;
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_BYTES = 4096;
	localparam int BLK_PAGES  = 1 << MAX_ORDER;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(PAGE_COUNT);

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TOO_BIG = 2'd1,
		ST_NO_MEM  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_SWEEP,
		CMD_ACCEPT,
		CMD_DECIDE,
		CMD_A_CLR,
		CMD_S_PUSH,
		CMD_S_LINK,
		CMD_M_READ,
		CMD_M_UNLINK,
		CMD_M_CLR,
		CMD_M_JOIN,
		CMD_P_PUSH,
		CMD_P_LINK,
		CMD_FIN
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic alloc_go;
		logic free_go;
		logic t_gt_want;
		logic o_lt_max;
		logic merge_ok;
		logic out_free;
	} dp_stat_t;

endpackage

@@ rtl/buddy_page_allocator_unit.sv @@
// Allocates run one split step per order split down; frees run one merge step per buddy
// joined; errors and ignored frees run no split or merge step.
// Throughput: one transaction at a time; the next is taken once the current result is registered.
// Rate is set by the page order, used and link memories walked by the controller.
// Reset: base_address clears, the result register empties, then a sweep over all 1024 pages
// writes the page memories with the initial free blocks; in_ready stays low during the sweep.
module buddy_page_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [bpa_pkg::SIZE_W-1:0]    request_size,
	input  logic [bpa_pkg::ADDR_W-1:0]    free_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [bpa_pkg::ADDR_W-1:0]    block_address,
	output logic [bpa_pkg::ORD_W-1:0]     block_order,
	input  logic                          cfg_wr_en,
	input  logic [bpa_pkg::ADDR_W-1:0]    cfg_wr_data
);
	import bpa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bpa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.opcode        (opcode),
		.request_size  (request_size),
		.free_address  (free_address),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.block_address (block_address),
		.block_order   (block_order)
	);

endmodule

@@ rtl/bpa_ctrl.sv @@
// Controller state machine: sequences the datapath through init sweep, split and merge steps.
// Depends on bpa_pkg.
module bpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bpa_pkg::dp_stat_t  stat,
	output bpa_pkg::dp_cmd_t   cmd
);
	import bpa_pkg::*;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_DECIDE,
		S_A_CLR,
		S_S1,
		S_S2,
		S_M_RD,
		S_M_CK,
		S_M_U1,
		S_M_U2,
		S_P2,
		S_FIN
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NOP;
		case (state_q)
			S_SWEEP: begin
				cmd = CMD_SWEEP;
				if (stat.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd     = CMD_ACCEPT;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd = CMD_DECIDE;
				if (stat.alloc_go) state_d = S_A_CLR;
				else if (stat.free_go) state_d = S_M_RD;
				else state_d = S_FIN;
			end
			S_A_CLR: begin
				cmd     = CMD_A_CLR;
				state_d = stat.t_gt_want ? S_S1 : S_FIN;
			end
			S_S1: begin
				cmd     = CMD_S_PUSH;
				state_d = S_S2;
			end
			S_S2: begin
				cmd     = CMD_S_LINK;
				state_d = stat.t_gt_want ? S_S1 : S_FIN;
			end
			S_M_RD: begin
				if (stat.o_lt_max) begin
					cmd     = CMD_M_READ;
					state_d = S_M_CK;
				end else begin
					cmd     = CMD_P_PUSH;
					state_d = S_P2;
				end
			end
			S_M_CK: begin
				if (stat.merge_ok) begin
					cmd     = CMD_M_UNLINK;
					state_d = S_M_U1;
				end else begin
					cmd     = CMD_P_PUSH;
					state_d = S_P2;
				end
			end
			S_M_U1: begin
				cmd     = CMD_M_CLR;
				state_d = S_M_U2;
			end
			S_M_U2: begin
				cmd     = CMD_M_JOIN;
				state_d = S_M_RD;
			end
			S_P2: begin
				cmd     = CMD_P_LINK;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd     = CMD_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

@@ rtl/bpa_dp.sv @@
// Datapath: per-page order, used and link memories, free-list heads, work and result registers.
// Depends on bpa_pkg; driven by bpa_ctrl commands.
module bpa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpa_pkg::dp_cmd_t              cmd,
	output bpa_pkg::dp_stat_t             stat,
	input  logic                          cfg_wr_en,
	input  logic [bpa_pkg::ADDR_W-1:0]    cfg_wr_data,
	input  logic                          opcode,
	input  logic [bpa_pkg::SIZE_W-1:0]    request_size,
	input  logic [bpa_pkg::ADDR_W-1:0]    free_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [bpa_pkg::ADDR_W-1:0]    block_address,
	output logic [bpa_pkg::ORD_W-1:0]     block_order
);
	import bpa_pkg::*;

	logic [ORD_W-1:0]  ord_mem  [PAGE_COUNT];
	logic              used_mem [PAGE_COUNT];
	logic [LINK_W-1:0] nxt_mem  [PAGE_COUNT];
	logic [LINK_W-1:0] prv_mem  [PAGE_COUNT];

	logic [ORD_W-1:0]  ord_rd;
	logic              used_rd;
	logic [LINK_W-1:0] nxt_rd, prv_rd;

	logic [ADDR_W-1:0] base_q;
	logic [PG_W-1:0]   sweep_q;
	logic [LINK_W-1:0] head_q [HEADS];
	logic              out_valid_q;

	logic              op_q, fits_q, found_q, pgok_q, grant_q;
	logic [ORD_W-1:0]  want_q, t_q, res_ord_q;
	logic [PG_W-1:0]   p_q, b_q;
	logic [LINK_W-1:0] h_q;
	status_t           res_st_q;
	status_t           out_st_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [ORD_W-1:0]  out_ord_q;

	logic              fits_c, found_c;
	logic [ORD_W-1:0]  want_c, tsel_c, tdn_c;
	logic [ADDR_W-1:0] off_c;
	logic              pgok_c;
	logic [PG_W-1:0]   psel_c, bm_c, bs_c, rd_addr;
	logic              sw_head;
	logic [LINK_W-1:0] sw_nxt, sw_prv, sw_up;

	logic              ord_we, used_we, nxt_we, prv_we;
	logic [PG_W-1:0]   ord_wa, used_wa, nxt_wa, prv_wa;
	logic [ORD_W-1:0]  ord_wd;
	logic              used_wd;
	logic [LINK_W-1:0] nxt_wd, prv_wd;

	always_comb begin
		fits_c = 1'b0;
		want_c = '0;
		for (int k = MAX_ORDER; k >= 0; k--) begin
			if ({1'b0, request_size} <= ((SIZE_W+1)'(PAGE_BYTES) << k)) begin
				fits_c = 1'b1;
				want_c = ORD_W'(k);
			end
		end
		found_c = 1'b0;
		tsel_c  = '0;
		for (int k = MAX_ORDER; k >= 0; k--) begin
			if ((ORD_W'(k) >= want_c) && (head_q[k] < NIL)) begin
				found_c = 1'b1;
				tsel_c  = ORD_W'(k);
			end
		end
	end

	assign off_c  = free_address - base_q;
	assign pgok_c = (off_c[ADDR_W-1:PAGE_SHIFT+PG_W] == '0);
	assign psel_c = opcode ? off_c[PAGE_SHIFT +: PG_W] : head_q[tsel_c][PG_W-1:0];
	assign bm_c   = p_q ^ (PG_W'(1) << t_q);
	assign tdn_c  = t_q - ORD_W'(1);
	assign bs_c   = p_q ^ (PG_W'(1) << tdn_c);

	assign sw_head = (sweep_q[MAX_ORDER-1:0] == '0);
	assign sw_up   = {1'b0, sweep_q} + LINK_W'(BLK_PAGES);
	assign sw_nxt  = (sw_head && sweep_q >= PG_W'(BLK_PAGES))
		? {1'b0, sweep_q - PG_W'(BLK_PAGES)} : NIL;
	assign sw_prv  = (sw_head && sw_up < NIL) ? sw_up : NIL;

	always_comb begin
		case (cmd)
			CMD_ACCEPT: rd_addr = psel_c;
			CMD_M_READ: rd_addr = bm_c;
			default:    rd_addr = p_q;
		endcase
	end

	always_comb begin
		ord_we  = 1'b0;  ord_wa  = p_q; ord_wd  = '0;
		used_we = 1'b0;  used_wa = p_q; used_wd = 1'b0;
		nxt_we  = 1'b0;  nxt_wa  = p_q; nxt_wd  = NIL;
		prv_we  = 1'b0;  prv_wa  = p_q; prv_wd  = NIL;
		case (cmd)
			CMD_SWEEP: begin
				ord_we  = 1'b1; ord_wa  = sweep_q;
				ord_wd  = sw_head ? ORD_W'(MAX_ORDER) : '0;
				used_we = 1'b1; used_wa = sweep_q;
				nxt_we  = 1'b1; nxt_wa  = sweep_q; nxt_wd = sw_nxt;
				prv_we  = 1'b1; prv_wa  = sweep_q; prv_wd = sw_prv;
			end
			CMD_DECIDE: begin
				if (stat.alloc_go) begin
					nxt_we = (prv_rd < NIL); nxt_wa = prv_rd[PG_W-1:0]; nxt_wd = nxt_rd;
					prv_we = (nxt_rd < NIL); prv_wa = nxt_rd[PG_W-1:0]; prv_wd = prv_rd;
				end
				if (stat.free_go) begin
					used_we = 1'b1;
				end
			end
			CMD_A_CLR: begin
				nxt_we = 1'b1;
				prv_we = 1'b1;
			end
			CMD_S_PUSH: begin
				ord_we  = 1'b1; ord_wa  = bs_c; ord_wd = tdn_c;
				used_we = 1'b1; used_wa = bs_c;
				nxt_we  = 1'b1; nxt_wa  = bs_c; nxt_wd = head_q[tdn_c];
				prv_we  = 1'b1; prv_wa  = bs_c;
			end
			CMD_S_LINK: begin
				prv_we = (h_q < NIL); prv_wa = h_q[PG_W-1:0]; prv_wd = {1'b0, b_q};
			end
			CMD_M_UNLINK: begin
				nxt_we = (prv_rd < NIL); nxt_wa = prv_rd[PG_W-1:0]; nxt_wd = nxt_rd;
				prv_we = (nxt_rd < NIL); prv_wa = nxt_rd[PG_W-1:0]; prv_wd = prv_rd;
			end
			CMD_M_CLR: begin
				ord_we = 1'b1; ord_wa = b_q; ord_wd = t_q + ORD_W'(1);
				nxt_we = 1'b1; nxt_wa = b_q;
				prv_we = 1'b1; prv_wa = b_q;
			end
			CMD_M_JOIN: begin
				ord_we = 1'b1; ord_wd = t_q;
			end
			CMD_P_PUSH: begin
				nxt_we = 1'b1; nxt_wd = head_q[t_q];
				prv_we = 1'b1;
			end
			CMD_P_LINK: begin
				prv_we = (h_q < NIL); prv_wa = h_q[PG_W-1:0]; prv_wd = {1'b0, p_q};
			end
			CMD_FIN: begin
				ord_we  = grant_q; ord_wd = want_q;
				used_we = grant_q; used_wd = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ord_we)  ord_mem[ord_wa]   <= ord_wd;
		if (used_we) used_mem[used_wa] <= used_wd;
		if (nxt_we)  nxt_mem[nxt_wa]   <= nxt_wd;
		if (prv_we)  prv_mem[prv_wa]   <= prv_wd;
		ord_rd  <= ord_mem[rd_addr];
		used_rd <= used_mem[rd_addr];
		nxt_rd  <= nxt_mem[rd_addr];
		prv_rd  <= prv_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < MAX_ORDER; k++) head_q[k] <= NIL;
			head_q[MAX_ORDER] <= LINK_W'((PAGE_COUNT / BLK_PAGES - 1) * BLK_PAGES);
		end else begin
			if (cfg_wr_en) base_q <= cfg_wr_data;
			if (cmd == CMD_SWEEP) sweep_q <= sweep_q + PG_W'(1);
			if (cmd == CMD_FIN) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (cmd)
				CMD_DECIDE:   if (stat.alloc_go && !(prv_rd < NIL)) head_q[t_q] <= nxt_rd;
				CMD_S_LINK:   head_q[t_q] <= {1'b0, b_q};
				CMD_M_UNLINK: if (!(prv_rd < NIL)) head_q[t_q] <= nxt_rd;
				CMD_P_LINK:   head_q[t_q] <= {1'b0, p_q};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_ACCEPT: begin
				op_q    <= opcode;
				fits_q  <= fits_c;
				found_q <= found_c;
				pgok_q  <= pgok_c;
				want_q  <= want_c;
				t_q     <= tsel_c;
				p_q     <= psel_c;
			end
			CMD_DECIDE: begin
				grant_q   <= stat.alloc_go;
				res_ord_q <= stat.alloc_go ? want_q : '0;
				if (!op_q && !fits_q) res_st_q <= ST_TOO_BIG;
				else if (!op_q && !found_q) res_st_q <= ST_NO_MEM;
				else res_st_q <= ST_OK;
				if (stat.free_go) t_q <= ord_rd;
			end
			CMD_S_PUSH: begin
				t_q <= tdn_c;
				b_q <= bs_c;
				h_q <= head_q[tdn_c];
			end
			CMD_M_READ: b_q <= bm_c;
			CMD_M_CLR:  t_q <= t_q + ORD_W'(1);
			CMD_M_JOIN: if (b_q < p_q) p_q <= b_q;
			CMD_P_PUSH: h_q <= head_q[t_q];
			CMD_P_LINK: res_ord_q <= t_q;
			CMD_FIN: begin
				out_st_q   <= res_st_q;
				out_ord_q  <= res_ord_q;
				out_addr_q <= grant_q
					? base_q + {{(ADDR_W-PG_W-PAGE_SHIFT){1'b0}}, p_q, {PAGE_SHIFT{1'b0}}}
					: '0;
			end
			default: ;
		endcase
	end

	assign stat.sweep_last = (sweep_q == PG_W'(PAGE_COUNT - 1));
	assign stat.alloc_go   = !op_q && fits_q && found_q;
	assign stat.free_go    = op_q && pgok_q && used_rd;
	assign stat.t_gt_want  = (t_q > want_q);
	assign stat.o_lt_max   = (t_q < ORD_W'(MAX_ORDER));
	assign stat.merge_ok   = (ord_rd == t_q) && !used_rd;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign status        = out_st_q;
	assign block_address = out_addr_q;
	assign block_order   = out_ord_q;

endmodule

@@ dv/buddy_page_allocator_unit_test.sv @@
// Self-checking testbench for buddy_page_allocator_unit: drives allocate and free
// transactions, predicts each result with an in-bench buddy allocator and checks the results.
// Depends on rtl/bpa_pkg.sv and rtl/buddy_page_allocator_unit.sv.
module buddy_page_allocator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bpa_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct {
		status_t          st;
		logic [ADDR_W-1:0] addr;
		logic [ORD_W-1:0]  ord;
	} grant_t;

	class buddy_scoreboard;
		logic [ADDR_W-1:0] base;
		int unsigned pg_ord[PAGE_COUNT];
		bit          pg_used[PAGE_COUNT];
		int unsigned nxt[PAGE_COUNT];
		int unsigned prv[PAGE_COUNT];
		int unsigned head[HEADS];
		grant_t      pending_q[$];
		int          errors;

		function new();
			int unsigned last;
			last = PAGE_COUNT;
			base = '0;
			errors = 0;
			for (int i = 0; i < PAGE_COUNT; i++) begin
				pg_ord[i] = 0; pg_used[i] = 0; nxt[i] = PAGE_COUNT; prv[i] = PAGE_COUNT;
			end
			for (int i = 0; i < HEADS; i++) head[i] = PAGE_COUNT;
			for (int i = 0; i + BLK_PAGES <= PAGE_COUNT; i += BLK_PAGES) begin
				pg_ord[i] = MAX_ORDER;
				nxt[i] = last;
				if (last < PAGE_COUNT) prv[last] = i;
				last = i;
			end
			head[MAX_ORDER] = last;
		endfunction

		function void push_block(int unsigned o, int unsigned p);
			nxt[p] = head[o];
			prv[p] = PAGE_COUNT;
			if (head[o] < PAGE_COUNT) prv[head[o]] = p;
			head[o] = p;
		endfunction

		function void unlink_block(int unsigned o, int unsigned p);
			int unsigned n, v;
			n = nxt[p];
			v = prv[p];
			if (v < PAGE_COUNT) nxt[v] = n;
			else head[o] = n;
			if (n < PAGE_COUNT) prv[n] = v;
			nxt[p] = PAGE_COUNT;
			prv[p] = PAGE_COUNT;
		endfunction

		function grant_t note_request(logic op, logic [SIZE_W-1:0] size,
				logic [ADDR_W-1:0] faddr);
			grant_t g;
			int unsigned want, t, p, o, b;
			logic [ADDR_W-1:0] off;
			bit fits;
			g.st = ST_OK; g.addr = '0; g.ord = '0;
			if (op == OP_ALLOC) begin
				fits = 0;
				want = 0;
				for (t = 0; t <= MAX_ORDER; t++)
					if (!fits && 64'(size) <= (64'(PAGE_BYTES) << t)) begin
						want = t; fits = 1;
					end
				if (!fits) g.st = ST_TOO_BIG;
				else begin
					t = want;
					while (t <= MAX_ORDER && head[t] >= PAGE_COUNT) t++;
					if (t > MAX_ORDER) g.st = ST_NO_MEM;
					else begin
						p = head[t];
						unlink_block(t, p);
						while (t > want) begin
							t--;
							pg_ord[p] = t;
							b = p ^ (1 << t);
							if (b < PAGE_COUNT) begin
								pg_ord[b] = t; pg_used[b] = 0;
								push_block(t, b);
							end
						end
						pg_ord[p] = want;
						pg_used[p] = 1;
						g.addr = base + ADDR_W'(p) * ADDR_W'(PAGE_BYTES);
						g.ord = ORD_W'(want);
					end
				end
			end else begin
				off = faddr - base;
				if ((off >> PAGE_SHIFT) < PAGE_COUNT && pg_used[off >> PAGE_SHIFT]) begin
					p = 32'(off >> PAGE_SHIFT);
					o = pg_ord[p];
					pg_used[p] = 0;
					while (o < MAX_ORDER) begin
						b = p ^ (1 << o);
						if (b >= PAGE_COUNT || pg_ord[b] != o || pg_used[b]) break;
						unlink_block(o, b);
						o++;
						pg_ord[b] = o; pg_ord[p] = o;
						if (b < p) p = b;
					end
					push_block(o, p);
					g.ord = ORD_W'(o);
				end
			end
			pending_q.push_back(g);
			return g;
		endfunction

		function void check_result(logic [1:0] st, logic [ADDR_W-1:0] a, logic [ORD_W-1:0] o);
			grant_t g;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result st=%0d addr=%h ord=%0d", st, a, o);
				return;
			end
			g = pending_q.pop_front();
			if (st !== g.st || a !== g.addr || o !== g.ord) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected st=%0d addr=%h ord=%0d, got st=%0d addr=%h ord=%0d",
						g.st, g.addr, g.ord, st, a, o);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                opcode;
	logic [SIZE_W-1:0]   request_size;
	logic [ADDR_W-1:0]   free_address;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          status;
	logic [ADDR_W-1:0]   block_address;
	logic [ORD_W-1:0]    block_order;
	logic                cfg_wr_en;
	logic [ADDR_W-1:0]   cfg_wr_data;

	buddy_scoreboard   sb;
	logic [ADDR_W-1:0] live_blocks[$];
	int                send_idle_pct;
	int                recv_stall_pct;
	int                quiet_cycles = 0;
	int                live_target;

	buddy_page_allocator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .request_size(request_size), .free_address(free_address),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .block_address(block_address), .block_order(block_order),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(status, block_address, block_order);
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("buddy_page_allocator_unit_test NOT OK");
			$finish;
		end
	end

	task automatic send_request(logic op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] faddr);
		grant_t g;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		request_size <= size;
		free_address <= faddr;
		do @(posedge clk); while (!in_ready);
		g = sb.note_request(op, size, faddr);
		if (op == OP_ALLOC && g.st == ST_OK) live_blocks.push_back(g.addr);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_base(logic [ADDR_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		sb.base = value;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned o;
		case ($urandom_range(19))
			0: return $urandom;
			1: return 32'h0002_0001 + $urandom_range(1000);
			2: return '0;
			default: begin
				o = $urandom_range(MAX_ORDER);
				return $urandom_range(PAGE_BYTES << o);
			end
		endcase
	endfunction

	task automatic free_live(bit keep_low);
		int idx;
		logic [ADDR_W-1:0] a;
		idx = $urandom_range(live_blocks.size() - 1);
		a = live_blocks[idx];
		live_blocks.delete(idx);
		if (!keep_low) a[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
		send_request(OP_FREE, $urandom, a);
	endtask

	task automatic random_phase(int count, int idle_pct, int stall_pct, bit hold_off);
		logic [ADDR_W-1:0] a;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) live_target = $urandom_range(10, 150);
			if (hold_off && n % 25 == 0) drain();
			case ($urandom_range(19))
				0: send_request(OP_FREE, $urandom, ADDR_W'({$urandom, $urandom}));
				1: begin
					a = sb.base + ADDR_W'($urandom_range(PAGE_COUNT - 1)) * ADDR_W'(PAGE_BYTES);
					send_request(OP_FREE, $urandom, a);
				end
				default:
					if (live_blocks.size() > 0 &&
							($urandom_range(99) < (live_blocks.size() > live_target ? 70 : 30)))
						free_live($urandom_range(1));
					else
						send_request(OP_ALLOC, pick_size(), ADDR_W'({$urandom, $urandom}));
			endcase
		end
		drain();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_ALLOC;
		request_size = '0;
		free_address = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		live_target = 50;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_base(48'hFFFF_FFFF_C000);
		send_request(OP_ALLOC, 32'd0, '0);
		send_request(OP_ALLOC, 32'd1, '1);
		send_request(OP_ALLOC, 32'd4096, '0);
		send_request(OP_ALLOC, 32'd4097, '0);
		send_request(OP_ALLOC, 32'h0002_0000, '0);
		send_request(OP_ALLOC, 32'h0002_0001, '0);
		send_request(OP_ALLOC, 32'hFFFF_FFFF, '0);
		send_request(OP_FREE, '1, 48'hFFFF_FFFF_C000 + 48'h1000 * PAGE_COUNT);
		send_request(OP_FREE, '0, 48'hFFFF_FFFF_C000 + 48'h1000 * 3);
		send_request(OP_FREE, '0, '1);
		send_request(OP_FREE, '1, live_blocks[1] | 48'hFFF);
		send_request(OP_FREE, '0, live_blocks[1]);
		for (int i = 0; i < 32; i++) send_request(OP_ALLOC, 32'h0002_0000, '0);
		while (live_blocks.size() > 0) free_live(1);
		drain();

		random_phase(300, 0, 0, 0);
		write_base('0);
		random_phase(300, 45, 0, 0);
		write_base(ADDR_W'({$urandom, $urandom}));
		random_phase(300, 0, 45, 1);
		write_base('1);
		random_phase(300, 14, 14, 0);

		if (sb.pending_q.size() != 0) sb.errors++;
		if (sb.errors == 0) $display("buddy_page_allocator_unit_test OK");
		else $display("buddy_page_allocator_unit_test NOT OK");
		$finish;
	end
endmodule
